### rtl/anf_pkg.sv
// Package with the shared types, constants and key table of the advertising name filter.
`timescale 1ns / 1ps

package anf_pkg;

	localparam int KEY_BYTES  = 23;
	localparam int COUNT_BITS = 32;
	localparam int IN_BITS    = 16;
	localparam int OUT_BITS   = 40;

	localparam logic [7:0] NAME_TYPE = 8'h09;
	localparam logic signed [7:0] RSSI_THRESHOLD_RESET = -8'sd56;

	localparam logic [7:0] KEY_TABLE [0:31] = '{
		8'h43, 8'h53, 8'h34, 8'h33, 8'h39, 8'h57, 8'h49, 8'h52,
		8'h45, 8'h4C, 8'h45, 8'h53, 8'h53, 8'h4E, 8'h45, 8'h54,
		8'h57, 8'h4F, 8'h52, 8'h4B, 8'h49, 8'h4E, 8'h47, 8'h00,
		8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00
	};

	typedef enum logic [3:0] {
		PH_LEN   = 4'b0001,
		PH_TYPE  = 4'b0010,
		PH_VALUE = 4'b0100,
		PH_DONE  = 4'b1000
	} phase_t;

	typedef struct packed {
		logic fire;
		logic last;
		logic matched;
	} parse_res_t;

endpackage

### rtl/anf_parser.sv
// Length-type-value walker that tracks per-packet state and flags a complete-name key match.
`timescale 1ns / 1ps

module anf_parser (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                fire,
	input  logic                last,
	input  logic [7:0]          ad_byte,
	output anf_pkg::parse_res_t res
);

	localparam logic [7:0] KEY_LEN8 = 8'(anf_pkg::KEY_BYTES);
	localparam logic [4:0] KEY_LEN5 = 5'(anf_pkg::KEY_BYTES);

	anf_pkg::phase_t phase_q, phase_d;
	logic [7:0] bytes_left_q, bytes_left_d, left_dec;
	logic [4:0] cmp_idx_q, cmp_idx_d;
	logic       cand_q, cand_d;
	logic       matched_q, matched_d;

	assign left_dec = bytes_left_q - 8'd1;

	always_comb begin
		phase_d      = phase_q;
		bytes_left_d = bytes_left_q;
		cmp_idx_d    = cmp_idx_q;
		cand_d       = cand_q;
		matched_d    = matched_q;
		unique case (phase_q)
			anf_pkg::PH_LEN: begin
				if (ad_byte == 8'd0) begin
					phase_d = anf_pkg::PH_DONE;
				end else begin
					bytes_left_d = ad_byte - 8'd1;
					phase_d      = anf_pkg::PH_TYPE;
				end
			end
			anf_pkg::PH_TYPE: begin
				cand_d    = (ad_byte == anf_pkg::NAME_TYPE) && (bytes_left_q == KEY_LEN8);
				cmp_idx_d = 5'd0;
				phase_d   = (bytes_left_q == 8'd0) ? anf_pkg::PH_LEN : anf_pkg::PH_VALUE;
			end
			anf_pkg::PH_VALUE: begin
				if (cand_q) begin
					if (cmp_idx_q >= KEY_LEN5 || ad_byte != anf_pkg::KEY_TABLE[cmp_idx_q]) begin
						cand_d = 1'b0;
					end
					cmp_idx_d = cmp_idx_q + 5'd1;
				end
				bytes_left_d = left_dec;
				if (left_dec == 8'd0) begin
					if (cand_d) begin
						matched_d = 1'b1;
						phase_d   = anf_pkg::PH_DONE;
					end else begin
						phase_d = anf_pkg::PH_LEN;
					end
				end
			end
			anf_pkg::PH_DONE: begin
				phase_d = anf_pkg::PH_DONE;
			end
			default: begin
				phase_d = anf_pkg::PH_LEN;
			end
		endcase
	end

	assign res.fire    = fire;
	assign res.last    = last;
	assign res.matched = matched_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= anf_pkg::PH_LEN;
			bytes_left_q <= 8'd0;
			cmp_idx_q    <= 5'd0;
			cand_q       <= 1'b0;
			matched_q    <= 1'b0;
		end else if (fire) begin
			if (last) begin
				phase_q      <= anf_pkg::PH_LEN;
				bytes_left_q <= 8'd0;
				cmp_idx_q    <= 5'd0;
				cand_q       <= 1'b0;
				matched_q    <= 1'b0;
			end else begin
				phase_q      <= phase_d;
				bytes_left_q <= bytes_left_d;
				cmp_idx_q    <= cmp_idx_d;
				cand_q       <= cand_d;
				matched_q    <= matched_d;
			end
		end
	end

endmodule

### rtl/anf_detect.sv
// Threshold register, detection counter and result register of the name filter.
`timescale 1ns / 1ps

module anf_detect (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_wen,
	input  logic signed [7:0]             cfg_wdata,
	input  anf_pkg::parse_res_t           res,
	input  logic signed [7:0]             signal_strength,
	input  logic                          out_ready,
	output logic                          out_valid,
	output logic [anf_pkg::OUT_BITS-1:0]  out_data
);

	logic signed [7:0]               thr_q;
	logic [anf_pkg::COUNT_BITS-1:0]  det_q, det_d;
	logic                            person;
	logic                            done;
	logic                            valid_q;
	logic [anf_pkg::OUT_BITS-1:0]    data_q;

	assign done   = res.fire && res.last;
	assign person = res.matched && (signal_strength < thr_q);
	assign det_d  = person ? det_q + anf_pkg::COUNT_BITS'(1) : det_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q   <= anf_pkg::RSSI_THRESHOLD_RESET;
			det_q   <= '0;
			valid_q <= 1'b0;
		end else begin
			if (cfg_wen) begin
				thr_q <= cfg_wdata;
			end
			if (done) begin
				det_q   <= det_d;
				valid_q <= 1'b1;
			end else if (out_ready) begin
				valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (done) begin
			data_q <= {6'd0, 32'(det_d), person, res.matched};
		end
	end

	assign out_valid = valid_q;
	assign out_data  = data_q;

endmodule

### rtl/adv_name_filter_rssi_counter.sv
// Top level of the advertising name filter with signal-strength walk counter.
`timescale 1ns / 1ps

// The slave stream carries one advertising payload byte per item, with tlast on the final
// byte of a packet and the signal strength sampled alongside it. Each packet's structures are
// walked as length, type and value bytes; a complete-name structure that holds the fixed key
// marks the packet as matched. On the last byte one item leaves on the master stream with the
// match flag, the detection flag (matched and signal below the threshold) and the running
// detection count, which wraps at 2^32.
// An item is first captured in an input register, then parsed; on the last byte of a packet
// its result is captured in the output register once that register is free. One item is
// taken every cycle; the only limit is the output register. When the receiver stalls, the
// result waits in the output register while non-last bytes keep flowing; a last byte waits
// in the input register until the output register is free.
// Reset clears the parser state, the count and both valid flags, and loads the threshold with
// -56 dBm. The threshold is written through cfg_wen and cfg_wdata; the user must write it
// only while the block is idle, and the block itself does not enforce this.

module adv_name_filter_rssi_counter (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_wen,
	input  logic signed [7:0]             cfg_wdata,
	input  logic                          s_axis_tvalid,
	output logic                          s_axis_tready,
	// ad_byte [7:0], signal_strength [15:8]
	input  logic [anf_pkg::IN_BITS-1:0]   s_axis_tdata,
	input  logic                          s_axis_tlast,
	output logic                          m_axis_tvalid,
	input  logic                          m_axis_tready,
	// name_matched [0], person_detected [1], walk_count [33:2], zero [39:34]
	output logic [anf_pkg::OUT_BITS-1:0]  m_axis_tdata
);

	logic                v_s1;
	logic                last_s1;
	logic [7:0]          byte_s1;
	logic signed [7:0]   sig_s1;
	logic                go_s1;
	logic                accept;
	anf_pkg::parse_res_t res;

	assign go_s1         = v_s1 && (!last_s1 || !m_axis_tvalid || m_axis_tready);
	assign s_axis_tready = !v_s1 || go_s1;
	assign accept        = s_axis_tvalid && s_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (accept) begin
			v_s1 <= 1'b1;
		end else if (go_s1) begin
			v_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			byte_s1 <= s_axis_tdata[7:0];
			sig_s1  <= s_axis_tdata[15:8];
			last_s1 <= s_axis_tlast;
		end
	end

	anf_parser u_parser (
		.clk     (clk),
		.arst_n  (arst_n),
		.fire    (go_s1),
		.last    (last_s1),
		.ad_byte (byte_s1),
		.res     (res)
	);

	anf_detect u_detect (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_wen         (cfg_wen),
		.cfg_wdata       (cfg_wdata),
		.res             (res),
		.signal_strength (sig_s1),
		.out_ready       (m_axis_tready),
		.out_valid       (m_axis_tvalid),
		.out_data        (m_axis_tdata)
	);

endmodule

### rtl/anf_checker.sv
// Port-level checker for the advertising name filter, bound to the top level.
`timescale 1ns / 1ps

module anf_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          s_axis_tready,
	input logic                          m_axis_tvalid,
	input logic                          m_axis_tready,
	input logic [anf_pkg::OUT_BITS-1:0]  m_axis_tdata
);

	// A stalled result keeps its payload.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("stalled result changed");

	// A detection is only possible on a matched packet.
	a_person_matched: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tdata[1] |-> m_axis_tdata[0])
		else $error("detection without name match");

	// The pad bits above the count stay zero.
	a_pad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> m_axis_tdata[anf_pkg::OUT_BITS-1:34] == 6'd0)
		else $error("nonzero pad bits in result");

	// No byte waits at the input when the output register is empty.
	a_flow: assert property (@(posedge clk) disable iff (!arst_n)
		!m_axis_tvalid |-> s_axis_tready)
		else $error("input stalled with empty output register");

endmodule

bind adv_name_filter_rssi_counter anf_checker u_anf_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tready (s_axis_tready),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata)
);
